@@ hw/rtl/bffa_pkg.sv @@
`default_nettype none

package bffa_pkg;

  localparam int NUM_BLOCKS = 64;
  localparam int BLK_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W      = BLK_W + 1;

  localparam int OFF_W   = 26;
  localparam int SIZE_W  = 27;
  localparam int SHIFT_W = 5;
  localparam int NEED_W  = SIZE_W + 1;

  localparam logic [SHIFT_W-1:0] SHIFT_MIN   = 5'd8;
  localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 5'd20;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd16;

  localparam int IN_TDATA_W  = ((SIZE_W + OFF_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((2 + OFF_W + SIZE_W + 7) / 8) * 8;

  typedef enum logic [0:0] {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_NO_SPACE = 2'd1,
    STS_BAD_FREE = 2'd2
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic do_free;
    logic do_zero;
    logic scan_step;
    logic scan_fail;
    logic scan_hit;
    logic emit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic func_free;
    logic need_zero;
    logic scan_end;
    logic scan_hit;
    logic out_busy;
  } sts_t;

  function automatic logic [SHIFT_W-1:0] eff_shift(input logic [SHIFT_W-1:0] sh);
    logic [SHIFT_W-1:0] r;
    r = sh;
    if (sh < SHIFT_MIN) r = SHIFT_MIN;
    if (sh > SHIFT_MAX) r = SHIFT_MAX;
    return r;
  endfunction

  // blocks whose offsets still fit the offset field
  function automatic logic [CNT_W-1:0] usable_blocks(input logic [SHIFT_W-1:0] sh);
    logic [SHIFT_W:0] room;
    logic [CNT_W-1:0] r;
    room = (SHIFT_W + 1)'(OFF_W) - {1'b0, sh};
    if (room >= (SHIFT_W + 1)'(BLK_W)) r = CNT_W'(NUM_BLOCKS);
    else r = CNT_W'(1) << room;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/bitmap_first_fit_block_allocator_top.sv @@
// First-fit block allocator over one heap chunk of NUM_BLOCKS blocks.
// Input stream (in_*): one transaction per request. in_tuser[0] is the
// operation (0 allocate, 1 free); in_tdata carries size_bytes and offset_bytes.
// Output stream (out_*): exactly one result transaction per request, in order,
// carrying status, grant_offset and grant_size.
// Config (cfg_*): writes block_shift (log2 block bytes); write only while idle.
// Flow: one request at a time. A free or a zero-size allocate goes from
// accept through a prep state straight to the response state. An allocate
// walks the free map one block per cycle from the search hint in a scan state,
// which ends on a grant or when the scan runs off the chunk end; the single-bit
// map read in the scan loop sets that rate.
// in_tready is high only while no request is in work; it rises in the same
// cycle as out_tvalid.
// Reset: all blocks free, hint 0, block_shift 16, no result pending.
// Stall: a result waits in the output register; the next request is accepted
// and processed, and its result is held back until out_tready drains the
// previous one.
`default_nettype none

module bitmap_first_fit_block_allocator_top (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    in_tvalid,
  output logic                                   in_tready,
  // [26:0] size_bytes, [52:27] offset_bytes, rest zero
  input  wire  [bffa_pkg::IN_TDATA_W-1:0]        in_tdata,
  // [0] func
  input  wire  [0:0]                             in_tuser,
  output logic                                   out_tvalid,
  input  wire                                    out_tready,
  // [1:0] status, [27:2] grant_offset, [54:28] grant_size, rest zero
  output logic [bffa_pkg::OUT_TDATA_W-1:0]       out_tdata,
  input  wire                                    cfg_valid,
  output logic                                   cfg_ready,
  input  wire  [bffa_pkg::SHIFT_W-1:0]           cfg_data
);

  bffa_pkg::cmd_t cmd;
  bffa_pkg::sts_t sts;

  logic [1:0]                  res_status;
  logic [bffa_pkg::OFF_W-1:0]  res_offset;
  logic [bffa_pkg::SIZE_W-1:0] res_size;

  assign cfg_ready = 1'b1;

  bffa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bffa_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_func    (in_tuser[0]),
    .in_size    (in_tdata[bffa_pkg::SIZE_W-1:0]),
    .in_offs    (in_tdata[bffa_pkg::SIZE_W+bffa_pkg::OFF_W-1:bffa_pkg::SIZE_W]),
    .cfg_wr     (cfg_valid && cfg_ready),
    .cfg_shift  (cfg_data),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (res_status),
    .out_offset (res_offset),
    .out_size   (res_size)
  );

  assign out_tdata = bffa_pkg::OUT_TDATA_W'({res_size, res_offset, res_status});

endmodule

`default_nettype wire

@@ hw/rtl/bffa_ctrl.sv @@
`default_nettype none

module bffa_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_ready,
  input  bffa_pkg::sts_t   sts,
  output bffa_pkg::cmd_t   cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PREP = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_RESP = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        if (sts.func_free) begin
          cmd.do_free = 1'b1;
          state_nxt   = ST_RESP;
        end else if (sts.need_zero) begin
          cmd.do_zero = 1'b1;
          state_nxt   = ST_RESP;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.scan_end) begin
          cmd.scan_fail = 1'b1;
          state_nxt     = ST_RESP;
        end else if (sts.scan_hit) begin
          cmd.scan_hit = 1'b1;
          state_nxt    = ST_RESP;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_RESP: begin
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command at once");

  a_scan_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan_hit || cmd.scan_fail) |=> (state_r == ST_RESP))
    else $error("scan finish did not move to response");

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("controller state is not one-hot");

endmodule

`default_nettype wire

@@ hw/rtl/bffa_dp.sv @@
`default_nettype none

module bffa_dp (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  bffa_pkg::cmd_t                       cmd,
  output bffa_pkg::sts_t                       sts,
  input  wire                                  in_func,
  input  wire  [bffa_pkg::SIZE_W-1:0]          in_size,
  input  wire  [bffa_pkg::OFF_W-1:0]           in_offs,
  input  wire                                  cfg_wr,
  input  wire  [bffa_pkg::SHIFT_W-1:0]         cfg_shift,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic [1:0]                           out_status,
  output logic [bffa_pkg::OFF_W-1:0]           out_offset,
  output logic [bffa_pkg::SIZE_W-1:0]          out_size
);

  localparam int NB   = bffa_pkg::NUM_BLOCKS;
  localparam int BW   = bffa_pkg::BLK_W;
  localparam int CW   = bffa_pkg::CNT_W;
  localparam int OW   = bffa_pkg::OFF_W;
  localparam int SW   = bffa_pkg::SIZE_W;
  localparam int NW   = bffa_pkg::NEED_W;

  logic [bffa_pkg::SHIFT_W-1:0] shift_r;
  logic [NB-1:0]                map_r, map_nxt;
  logic [BW-1:0]                hint_r;
  logic                         func_r;
  logic [SW-1:0]                size_r;
  logic [OW-1:0]                offs_r;
  logic [NW-1:0]                need_r;
  logic [CW-1:0]                idx_r, start_r, run_r;

  logic [1:0]                   res_status_r;
  logic [OW-1:0]                res_off_r;
  logic [SW-1:0]                res_size_r;
  logic                         out_valid_r;
  logic [1:0]                   out_status_r;
  logic [OW-1:0]                out_off_r;
  logic [SW-1:0]                out_size_r;

  logic [bffa_pkg::SHIFT_W-1:0] sh;
  logic [CW-1:0]                blocks_e;
  logic [NW-1:0]                need_in, round_mask;
  logic                         cur_free;
  logic [CW-1:0]                run_inc;
  logic [SW-1:0]                fr_start, fr_cnt, fr_e;
  logic                         fr_bad;
  logic [SW-1:0]                fr_jj;
  logic [CW-1:0]                jj;

  assign sh       = bffa_pkg::eff_shift(shift_r);
  assign blocks_e = bffa_pkg::usable_blocks(sh);

  // ceil(size / block): add block-1, then shift
  assign round_mask = ~({NW{1'b1}} << sh);
  assign need_in    = ({1'b0, in_size} + round_mask) >> sh;

  assign cur_free = map_r[idx_r[BW-1:0]];
  assign run_inc  = run_r + CW'(1);

  assign fr_start = {1'b0, offs_r >> sh};
  assign fr_cnt   = size_r >> sh;
  assign fr_e     = SW'(blocks_e);
  assign fr_bad   = (fr_start >= fr_e) || (fr_cnt > (fr_e - fr_start));

  assign sts.func_free = (func_r == bffa_pkg::FUNC_FREE);
  assign sts.need_zero = (need_r == '0);
  assign sts.scan_end  = (idx_r >= blocks_e);
  assign sts.scan_hit  = cur_free && ({{(NW-CW){1'b0}}, run_inc} >= need_r);
  assign sts.out_busy  = out_valid_r && !out_ready;

  always_comb begin
    map_nxt = map_r;
    jj      = '0;
    fr_jj   = '0;
    for (int j = 0; j < NB; j++) begin
      jj    = CW'(j);
      fr_jj = SW'(j);
      if (cmd.scan_hit && (jj >= start_r) && (jj <= idx_r)) map_nxt[j] = 1'b0;
      if (cmd.do_free && !fr_bad && (fr_jj >= fr_start) && ((fr_jj - fr_start) < fr_cnt))
        map_nxt[j] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r     <= bffa_pkg::SHIFT_RESET;
      map_r       <= '1;
      hint_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) shift_r <= cfg_shift;
      map_r <= map_nxt;
      if (cmd.do_free && !fr_bad) hint_r <= fr_start[BW-1:0];
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= in_func;
      size_r  <= in_size;
      offs_r  <= in_offs;
      need_r  <= need_in;
      idx_r   <= {1'b0, hint_r};
      start_r <= {1'b0, hint_r};
      run_r   <= '0;
    end
    if (cmd.scan_step) begin
      idx_r <= idx_r + CW'(1);
      if (cur_free) begin
        run_r <= run_inc;
      end else begin
        start_r <= idx_r + CW'(1);
        run_r   <= '0;
      end
    end
    if (cmd.do_zero) begin
      res_status_r <= bffa_pkg::STS_OK;
      res_off_r    <= OW'({1'b0, hint_r}) << sh;
      res_size_r   <= '0;
    end
    if (cmd.scan_fail) begin
      res_status_r <= bffa_pkg::STS_NO_SPACE;
      res_off_r    <= '0;
      res_size_r   <= '0;
    end
    if (cmd.scan_hit) begin
      res_status_r <= bffa_pkg::STS_OK;
      res_off_r    <= OW'(start_r) << sh;
      res_size_r   <= SW'(need_r << sh);
    end
    if (cmd.do_free) begin
      res_off_r <= offs_r;
      if (fr_bad) begin
        res_status_r <= bffa_pkg::STS_BAD_FREE;
        res_size_r   <= '0;
      end else begin
        res_status_r <= bffa_pkg::STS_OK;
        res_size_r   <= fr_cnt << sh;
      end
    end
    if (cmd.emit) begin
      out_status_r <= res_status_r;
      out_off_r    <= res_off_r;
      out_size_r   <= res_size_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_offset = out_off_r;
  assign out_size   = out_size_r;

  a_emit_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(out_valid_r && !out_ready))
    else $error("result overwrote an untaken result");

  a_hit_marks_used: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_hit |=> !map_r[$past(idx_r[BW-1:0])])
    else $error("granted block still marked free");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan_step || cmd.scan_hit) |-> (idx_r < blocks_e))
    else $error("scan read past usable chunk");

endmodule

`default_nettype wire

@@ verif/bitmap_first_fit_block_allocator_top_test.sv @@
`default_nettype none

module bitmap_first_fit_block_allocator_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bffa_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int BLK16       = 65536;

  typedef struct packed {
    status_t     st;
    logic [25:0] goff;
    logic [26:0] gsz;
  } grant_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [0:0]             in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [SHIFT_W-1:0]     cfg_data;

  bitmap_first_fit_block_allocator_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // allocator mirror
  logic [NUM_BLOCKS-1:0] free_map  = '1;
  int unsigned           scan_hint = 0;
  logic [SHIFT_W-1:0]    cur_shift = SHIFT_RESET;

  grant_t      pending_grants[$];
  logic [25:0] live_off[$];
  logic [26:0] live_len[$];

  int mismatches  = 0;
  int hold_cycles = 0;
  bit no_gaps     = 0;
  bit sink_calm   = 0;
  int idle_count  = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int clamp_shift(input logic [SHIFT_W-1:0] sh);
    if (sh < 8) return 8;
    if (sh > 20) return 20;
    return int'(sh);
  endfunction

  function automatic grant_t apply_request(input func_t f, input logic [26:0] sz,
                                           input logic [25:0] off);
    grant_t           g;
    int               sh;
    longint unsigned  lim, need, start, run, cnt, s, i, size_v;
    bit               found;
    sh     = clamp_shift(cur_shift);
    lim    = (64'd1 << 26) >> sh;
    if (lim > NUM_BLOCKS) lim = NUM_BLOCKS;
    size_v = sz;
    g.st   = STS_OK;
    g.goff = '0;
    g.gsz  = '0;
    if (f == FUNC_ALLOC) begin
      need = (size_v + (64'd1 << sh) - 1) >> sh;
      if (need == 0) begin
        g.goff = 26'(longint'(scan_hint) << sh);
      end else begin
        start = scan_hint;
        run   = 0;
        found = 0;
        for (i = scan_hint; i < lim && !found; i++) begin
          if (free_map[i]) begin
            run++;
            if (run >= need) found = 1;
          end else begin
            // a used block restarts the run past it
            start = i + 1;
            run   = 0;
          end
        end
        if (found) begin
          for (i = start; i < start + need; i++) free_map[i] = 1'b0;
          g.goff = 26'(start << sh);
          g.gsz  = 27'(need << sh);
        end else begin
          g.st = STS_NO_SPACE;
        end
      end
    end else begin
      s      = longint'(off) >> sh;
      cnt    = size_v >> sh;
      g.goff = off;
      if (s >= lim || cnt > lim - s) begin
        g.st = STS_BAD_FREE;
      end else begin
        for (i = s; i < s + cnt; i++) free_map[i] = 1'b1;
        scan_hint = int'(s);
        g.gsz     = 27'(cnt << sh);
      end
    end
    return g;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic send_req(input func_t f, input logic [26:0] sz, input logic [25:0] off,
                          output grant_t g);
    if (!no_gaps && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= IN_TDATA_W'({off, sz});
    do @(posedge clk); while (!in_tready);
    g = apply_request(f, sz, off);
    pending_grants.push_back(g);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
  endtask

  task automatic set_shift(input logic [SHIFT_W-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cur_shift = v;
    cfg_valid <= 1'b0;
  endtask

  // free the whole chunk: map all ones, hint back to zero
  task automatic reset_heap();
    grant_t g;
    send_req(FUNC_FREE, 27'(64'(NUM_BLOCKS) << clamp_shift(cur_shift)), '0, g);
    live_off.delete();
    live_len.delete();
  endtask

  task automatic random_traffic(input int n);
    grant_t      g;
    int          sh, r, nb, pick;
    logic [26:0] sz;
    logic [25:0] off;
    for (int k = 0; k < n; k++) begin
      sh = clamp_shift(cur_shift);
      r  = $urandom_range(0, 99);
      if (r < 45 || (r < 80 && live_off.size() == 0)) begin
        nb = ($urandom_range(0, 9) == 0) ? $urandom_range(7, NUM_BLOCKS)
                                          : $urandom_range(1, 6);
        if ($urandom_range(0, 19) == 0) nb = 0;
        sz = (nb == 0) ? '0
                       : 27'((longint'(nb) << sh) - $urandom_range(0, (1 << sh) - 1));
        send_req(FUNC_ALLOC, sz, 26'($urandom), g);
        if (g.st == STS_OK && g.gsz != 0) begin
          live_off.push_back(g.goff);
          live_len.push_back(($urandom_range(0, 3) == 0) ? sz : g.gsz);
        end
      end else if (r < 80) begin
        pick = $urandom_range(0, live_off.size() - 1);
        off  = live_off[pick];
        if ($urandom_range(0, 3) == 0) off = off | 26'($urandom & ((1 << sh) - 1));
        send_req(FUNC_FREE, live_len[pick], off, g);
        live_off.delete(pick);
        live_len.delete(pick);
      end else if (r < 90) begin
        // in or near range free with loose alignment
        off = 26'(($urandom_range(0, NUM_BLOCKS + 6) << sh) | ($urandom & ((1 << sh) - 1)));
        sz  = 27'(($urandom_range(0, 12) << sh) | ($urandom & ((1 << sh) - 1)));
        send_req(FUNC_FREE, sz, off, g);
      end else if (r < 95) begin
        send_req(FUNC_FREE, 27'($urandom), 26'($urandom), g);
      end else begin
        send_req(FUNC_ALLOC, 27'($urandom), 26'($urandom), g);
      end
    end
  endtask

  task automatic test_directed();
    grant_t g;
    send_req(FUNC_ALLOC, 27'd0, '0, g);                        // zero size at hint 0
    send_req(FUNC_ALLOC, 27'd1, 26'h3FFFFFF, g);
    send_req(FUNC_ALLOC, 27'(BLK16), '0, g);
    send_req(FUNC_ALLOC, 27'(BLK16 + 1), '0, g);
    send_req(FUNC_ALLOC, 27'h7FFFFFF, '0, g);                  // far too big
    send_req(FUNC_FREE, 27'(BLK16), 26'(BLK16), g);            // hint -> 1
    send_req(FUNC_ALLOC, 27'(2 * BLK16), '0, g);               // used block restarts run
    send_req(FUNC_ALLOC, 27'd0, '0, g);                        // echoes hint offset
    send_req(FUNC_FREE, 27'd1, 26'(NUM_BLOCKS * BLK16), g);    // start past chunk
    send_req(FUNC_FREE, 27'(5 * BLK16), 26'(60 * BLK16), g);   // run passes chunk end
    send_req(FUNC_FREE, 27'd0, 26'h3FFFFFF, g);
    send_req(FUNC_FREE, 27'(BLK16 + 100), 26'd123, g);         // unaligned, partial block
    send_req(FUNC_ALLOC, 27'(58 * BLK16), '0, g);              // ends exactly at chunk end
    send_req(FUNC_ALLOC, 27'(BLK16), '0, g);
    send_req(FUNC_ALLOC, 27'(2 * BLK16), '0, g);               // no space
    send_req(FUNC_FREE, 27'h4000000, '0, g);
    send_req(FUNC_FREE, 27'(NUM_BLOCKS * BLK16), '0, g);
    send_req(FUNC_FREE, 27'd0, 26'(63 * BLK16), g);            // empty free moves hint
    send_req(FUNC_ALLOC, 27'(BLK16), '0, g);                   // last block
    send_req(FUNC_ALLOC, 27'd1, '0, g);                        // hint at end, no wrap
    send_req(FUNC_FREE, 27'(NUM_BLOCKS * BLK16), '0, g);
    send_req(FUNC_ALLOC, 27'(NUM_BLOCKS * BLK16), '0, g);      // whole chunk
    send_req(FUNC_ALLOC, 27'd0, '0, g);
    reset_heap();
    drain();
  endtask

  task automatic test_shift_sweep();
    grant_t             g;
    logic [SHIFT_W-1:0] shifts[8];
    shifts = '{5'd0, 5'd8, 5'd31, 5'd20, 5'd7, 5'd21, 5'($urandom_range(9, 19)), SHIFT_RESET};
    foreach (shifts[k]) begin
      set_shift(shifts[k]);
      reset_heap();
      send_req(FUNC_ALLOC, 27'(64'(NUM_BLOCKS) << clamp_shift(cur_shift)), '0, g);
      send_req(FUNC_ALLOC, 27'd1, '0, g);
      reset_heap();
      random_traffic(140);
      reset_heap();
    end
    drain();
  endtask

  task automatic test_backpressure();
    grant_t g;
    no_gaps     = 1;
    hold_cycles = 400;
    for (int k = 0; k < 16; k++)
      send_req(FUNC_ALLOC, 27'(1 << clamp_shift(cur_shift)), 26'($urandom), g);
    random_traffic(40);
    no_gaps = 0;
    reset_heap();
    drain();
  endtask

  task automatic test_no_idle();
    no_gaps   = 1;
    sink_calm = 1;
    random_traffic(150);
    reset_heap();
    drain();
  endtask

  // result sink: random stall bursts, one long hold on request
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles != 0) begin
        out_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
        out_tready <= 1'b1;
      end else if (!sink_calm && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_grant
    grant_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_grants.size() == 0) begin
        report_mismatch($sformatf("unexpected result transaction tdata=%h", out_tdata));
      end else begin
        want = pending_grants.pop_front();
        if (out_tdata[1:0] != want.st)
          report_mismatch($sformatf("status got %0d want %0d", out_tdata[1:0], want.st));
        if (out_tdata[27:2] != want.goff)
          report_mismatch($sformatf("grant_offset got %0d want %0d",
                                    out_tdata[27:2], want.goff));
        if (out_tdata[54:28] != want.gsz)
          report_mismatch($sformatf("grant_size got %0d want %0d",
                                    out_tdata[54:28], want.gsz));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_count <= 0;
    else
      idle_count <= idle_count + 1;
    if (idle_count >= STALL_LIMIT) begin
      $display("bitmap_first_fit_block_allocator_top verification failed");
      $finish;
    end
  end

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_shift_sweep();
    test_backpressure();
    test_no_idle();

    repeat (NUM_BLOCKS + 8) @(posedge clk);
    if (pending_grants.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_grants.size()));
    if (mismatches == 0)
      $display("bitmap_first_fit_block_allocator_top verification clean");
    else
      $display("bitmap_first_fit_block_allocator_top verification failed");
    $finish;
  end

endmodule

`default_nettype wire
